// File: rtl/perspective_world_to_screen_top_defines.svh
// Assertion macros for the world-to-screen projection block.
// Used by perspective_world_to_screen_top; depends on nothing else.
`ifndef PERSPECTIVE_WORLD_TO_SCREEN_TOP_DEFINES_SVH
`define PERSPECTIVE_WORLD_TO_SCREEN_TOP_DEFINES_SVH

// same-cycle implication
`define PWTS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PWTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/pwts_pkg.sv
// Shared types, constants and arithmetic helpers for the projection block.
// No dependencies.
package pwts_pkg;

    localparam int COEF_FRAC_BITS = 16;
    localparam int CFG_W          = 64;
    localparam int CFG_IDX_W      = 4;
    localparam int DIM_W          = 15;
    localparam int COORD_W        = 32;
    localparam int PROD_W         = 2 * COORD_W;
    localparam int FLOOR_SHIFT    = 8;
    localparam int DOT_W          = 58;
    localparam int RATIO_FRAC     = 24;
    localparam int QUO_W          = 2 * RATIO_FRAC;
    localparam int DIV_STAGES     = QUO_W;
    localparam int SCALE_SHIFT    = 7;
    localparam int SCALE_W        = DIM_W + SCALE_SHIFT;
    localparam int HALF_PROD_W    = RATIO_FRAC + SCALE_W;
    localparam int MAG_W          = HALF_PROD_W + 1;
    localparam int W_MIN_PIX      = 655;

    localparam logic [DIM_W-1:0] DISP_W_RST = DIM_W'(1920);
    localparam logic [DIM_W-1:0] DISP_H_RST = DIM_W'(1080);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_LO,
        CFG_X_HI,
        CFG_Y_LO,
        CFG_Y_HI,
        CFG_W_LO,
        CFG_W_HI,
        CFG_DISP_W,
        CFG_DISP_H
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COORD_W-1:0] world_x;
        logic signed [COORD_W-1:0] world_y;
        logic signed [COORD_W-1:0] world_z;
    } t_in_item;

    typedef struct packed {
        logic                      projection_valid;
        logic signed [COORD_W-1:0] screen_x;
        logic signed [COORD_W-1:0] screen_y;
    } t_out_item;

    typedef struct packed {
        logic [DOT_W-1:0]      rem;
        logic [QUO_W-1:0]      quo;
        logic [RATIO_FRAC-1:0] nlo;
        logic                  sat;
        logic                  neg;
    } t_div_lane;

    function automatic logic signed [DOT_W-1:0] floor_term(logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] s;
        s = p >>> FLOOR_SHIFT;
        return DOT_W'(s);
    endfunction

    // take |t| apart: integer part seeds the remainder, low bits feed the steps
    function automatic t_div_lane lane_prep(logic signed [DOT_W:0] t, logic [DOT_W-1:0] d);
        t_div_lane         l;
        logic [DOT_W:0]    a;
        logic [DOT_W-1:0]  n;
        a = t[DOT_W] ? DOT_W'(0) - t : t;
        n = a[DOT_W-1:0];
        l.neg = t[DOT_W];
        l.rem = DOT_W'(n[DOT_W-1:RATIO_FRAC]);
        l.nlo = n[RATIO_FRAC-1:0];
        l.quo = '0;
        l.sat = (DOT_W'(n[DOT_W-1:RATIO_FRAC]) >= d);
        return l;
    endfunction

    function automatic t_div_lane div_step(t_div_lane l, logic [DOT_W-1:0] d);
        t_div_lane        o;
        logic [DOT_W-1:0] trial;
        o = l;
        trial = {l.rem[DOT_W-2:0], l.nlo[RATIO_FRAC-1]};
        o.nlo = {l.nlo[RATIO_FRAC-2:0], 1'b0};
        if (trial >= d) begin
            o.rem = trial - d;
            o.quo = {l.quo[QUO_W-2:0], 1'b1};
        end else begin
            o.rem = trial;
            o.quo = {l.quo[QUO_W-2:0], 1'b0};
        end
        return o;
    endfunction

    // combine partial products (zero on zero scale, full scale on sat), clamp and apply sign (rounds toward zero)
    function automatic logic [COORD_W-1:0] finish(logic [HALF_PROD_W-1:0] hi_p,
                                                  logic [HALF_PROD_W-1:0] lo_p,
                                                  logic sat, logic neg, logic zero_scale);
        logic [MAG_W-1:0]   mag;
        logic [COORD_W:0]   clip;
        mag = MAG_W'(hi_p) + MAG_W'(lo_p >> RATIO_FRAC);
        if (zero_scale) begin
            mag = '0;
        end else if (sat) begin
            mag = MAG_W'(1) << (COORD_W - 1);
        end
        if (!neg) begin
            if (mag > MAG_W'({1'b0, {(COORD_W-1){1'b1}}}))
                clip = (COORD_W+1)'({1'b0, {(COORD_W-1){1'b1}}});
            else
                clip = (COORD_W+1)'(mag);
            return clip[COORD_W-1:0];
        end
        if (mag > (MAG_W'(1) << (COORD_W - 1)))
            clip = (COORD_W+1)'(1) << (COORD_W - 1);
        else
            clip = (COORD_W+1)'(mag);
        clip = (COORD_W+1)'(0) - clip;
        return clip[COORD_W-1:0];
    endfunction

endpackage

// File: rtl/perspective_world_to_screen_top.sv
// Perspective world-to-screen projection, fully pipelined.
// Depends on pwts_pkg and perspective_world_to_screen_top_defines.svh.
`include "perspective_world_to_screen_top_defines.svh"

// Takes one world point per cycle and returns one screen point per item, in order.
// Four stages form the three matrix row dot products, one
// stage sets up the divide, 48 stages of a restoring divider (one quotient bit
// each, two lanes for x and y) form the 24.24 ratio, and two stages scale by the
// display size and clamp. Throughput is one item per cycle; the whole pipe holds
// only while the output register is full and stalled. Write configuration only
// while no item is in flight.
module perspective_world_to_screen_top #(
    parameter int COEF_FRAC_BITS = pwts_pkg::COEF_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  pwts_pkg::t_in_item                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output pwts_pkg::t_out_item               o_out_data,
    input  logic                              i_cfg_we,
    input  logic [pwts_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pwts_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam int DOT_W   = pwts_pkg::DOT_W;
    localparam int PROD_W  = pwts_pkg::PROD_W;
    localparam int COORD_W = pwts_pkg::COORD_W;
    localparam int DIV_N   = pwts_pkg::DIV_STAGES;
    localparam int HP_W    = pwts_pkg::HALF_PROD_W;
    localparam int RF      = pwts_pkg::RATIO_FRAC;
    localparam logic signed [DOT_W-1:0] W_MIN =
        DOT_W'(pwts_pkg::W_MIN_PIX) <<< (COEF_FRAC_BITS - pwts_pkg::FLOOR_SHIFT);

    // configuration: rows x, y, w
    logic [pwts_pkg::CFG_W-1:0]   r_row_lo [0:2];
    logic [pwts_pkg::CFG_W-1:0]   r_row_hi [0:2];
    logic [pwts_pkg::DIM_W-1:0]   r_dim_w;
    logic [pwts_pkg::DIM_W-1:0]   r_dim_h;

    logic en;

    logic                         r_v0;
    pwts_pkg::t_in_item           r_pt;
    logic                         r_v1;
    logic signed [PROD_W-1:0]     r_prod [0:2][0:2];
    logic signed [PROD_W-1:0]     n_prod [0:2][0:2];
    logic                         r_v2;
    logic signed [DOT_W-1:0]      r_part_a [0:2];
    logic signed [DOT_W-1:0]      r_part_b [0:2];
    logic signed [DOT_W-1:0]      n_part_a [0:2];
    logic signed [DOT_W-1:0]      n_part_b [0:2];
    logic                         r_v3;
    logic signed [DOT_W-1:0]      r_dot [0:2];

    logic                         r_dv  [0:DIV_N];
    logic                         r_dok [0:DIV_N];
    logic [DOT_W-1:0]             r_dd  [0:DIV_N];
    pwts_pkg::t_div_lane          r_dl  [0:DIV_N][0:1];
    pwts_pkg::t_div_lane          n_dl  [1:DIV_N][0:1];

    logic                         n_ok;
    logic [DOT_W-1:0]             n_d;
    logic signed [DOT_W:0]        n_tx;
    logic signed [DOT_W:0]        n_ty;

    logic                         r_mv;
    logic                         r_mok;
    logic [HP_W-1:0]              r_mhi [0:1];
    logic [HP_W-1:0]              r_mlo [0:1];
    logic                         r_msat [0:1];
    logic                         r_mneg [0:1];
    logic [pwts_pkg::SCALE_W-1:0] scale [0:1];

    logic                         r_out_valid;
    pwts_pkg::t_out_item          r_out;

    assign en          = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !en;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign scale[0] = {r_dim_w, pwts_pkg::SCALE_SHIFT'(0)};
    assign scale[1] = {r_dim_h, pwts_pkg::SCALE_SHIFT'(0)};

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_prod[r][0] = $signed(r_row_lo[r][COORD_W-1:0]) * r_pt.world_x;
            n_prod[r][1] = $signed(r_row_lo[r][2*COORD_W-1:COORD_W]) * r_pt.world_y;
            n_prod[r][2] = $signed(r_row_hi[r][COORD_W-1:0]) * r_pt.world_z;
            n_part_a[r]  = pwts_pkg::floor_term(r_prod[r][0])
                         + pwts_pkg::floor_term(r_prod[r][1]);
            // column 3 enters scaled up by the floor shift
            n_part_b[r]  = pwts_pkg::floor_term(r_prod[r][2])
                         + (DOT_W'($signed(r_row_hi[r][2*COORD_W-1:COORD_W]))
                            <<< pwts_pkg::FLOOR_SHIFT);
        end
    end

    always_comb begin
        n_ok = (r_row_hi[2][2*COORD_W-1:COORD_W] != '0) && (r_dot[2] >= W_MIN);
        n_d  = r_dot[2];
        n_tx = (DOT_W+1)'(r_dot[2]) + (DOT_W+1)'(r_dot[0]);
        n_ty = (DOT_W+1)'(r_dot[2]) - (DOT_W+1)'(r_dot[1]);
    end

    always_comb begin
        for (int k = 0; k < DIV_N; k++) begin
            for (int l = 0; l < 2; l++) begin
                n_dl[k+1][l] = pwts_pkg::div_step(r_dl[k][l], r_dd[k]);
            end
        end
    end

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                r_row_lo[r] <= '0;
                r_row_hi[r] <= '0;
            end
            r_dim_w <= pwts_pkg::DISP_W_RST;
            r_dim_h <= pwts_pkg::DISP_H_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pwts_pkg::CFG_X_LO:   r_row_lo[0] <= i_cfg_data;
                pwts_pkg::CFG_X_HI:   r_row_hi[0] <= i_cfg_data;
                pwts_pkg::CFG_Y_LO:   r_row_lo[1] <= i_cfg_data;
                pwts_pkg::CFG_Y_HI:   r_row_hi[1] <= i_cfg_data;
                pwts_pkg::CFG_W_LO:   r_row_lo[2] <= i_cfg_data;
                pwts_pkg::CFG_W_HI:   r_row_hi[2] <= i_cfg_data;
                pwts_pkg::CFG_DISP_W: r_dim_w <= i_cfg_data[pwts_pkg::DIM_W-1:0];
                pwts_pkg::CFG_DISP_H: r_dim_h <= i_cfg_data[pwts_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            for (int k = 0; k <= DIV_N; k++) begin
                r_dv[k] <= 1'b0;
            end
            r_mv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_v0    <= i_in_valid;
            r_v1    <= r_v0;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_dv[0] <= r_v3;
            for (int k = 0; k < DIV_N; k++) begin
                r_dv[k+1] <= r_dv[k];
            end
            r_mv        <= r_dv[DIV_N];
            r_out_valid <= r_mv;
        end
    end

    // payload: advance everything together, hold on stall
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pt <= i_in_data;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_prod[r][c] <= n_prod[r][c];
                end
                r_part_a[r] <= n_part_a[r];
                r_part_b[r] <= n_part_b[r];
                r_dot[r]    <= r_part_a[r] + r_part_b[r];
            end
            r_dok[0]   <= n_ok;
            r_dd[0]    <= n_d;
            r_dl[0][0] <= pwts_pkg::lane_prep(n_tx, n_d);
            r_dl[0][1] <= pwts_pkg::lane_prep(n_ty, n_d);
            for (int k = 0; k < DIV_N; k++) begin
                r_dok[k+1] <= r_dok[k];
                r_dd[k+1]  <= r_dd[k];
                for (int l = 0; l < 2; l++) begin
                    r_dl[k+1][l] <= n_dl[k+1][l];
                end
            end
            r_mok <= r_dok[DIV_N];
            for (int l = 0; l < 2; l++) begin
                r_mhi[l]  <= HP_W'(r_dl[DIV_N][l].quo[2*RF-1:RF]) * HP_W'(scale[l]);
                r_mlo[l]  <= HP_W'(r_dl[DIV_N][l].quo[RF-1:0]) * HP_W'(scale[l]);
                r_msat[l] <= r_dl[DIV_N][l].sat;
                r_mneg[l] <= r_dl[DIV_N][l].neg;
            end
            r_out.projection_valid <= r_mok;
            if (r_mok) begin
                r_out.screen_x <= pwts_pkg::finish(r_mhi[0], r_mlo[0], r_msat[0],
                                                   r_mneg[0], r_dim_w == '0);
                r_out.screen_y <= pwts_pkg::finish(r_mhi[1], r_mlo[1], r_msat[1],
                                                   r_mneg[1], r_dim_h == '0);
            end else begin
                r_out.screen_x <= '0;
                r_out.screen_y <= '0;
            end
        end
    end

    `PWTS_ASSERT_IMPLY(a_invalid_zero, i_clk, i_rst_n, o_out_valid && !o_out_data.projection_valid, o_out_data.screen_x == '0 && o_out_data.screen_y == '0, "invalid item carries nonzero screen fields")
    `PWTS_ASSERT_IMPLY(a_rem_below_div, i_clk, i_rst_n, r_dv[0] && r_dok[0] && !r_dl[0][0].sat, r_dl[0][0].rem < r_dd[0], "divider seed not below divisor")
    `PWTS_ASSERT_NEXT(a_div_drain, i_clk, i_rst_n, en && r_dv[DIV_N], r_mv, "item lost leaving divider")
    `PWTS_ASSERT_IMPLY(a_zero_width, i_clk, i_rst_n, o_out_valid && r_dim_w == '0, o_out_data.screen_x == '0, "zero width gives nonzero screen x")

endmodule
